// ===== rtl/cpac_pkg.sv =====
// Shared types, constants and helper functions for the camera pitch angle correction block.
`timescale 1ns / 1ps

package cpac_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int VAL_W = 34;
    localparam int QBITS = 30;
    localparam int UNIT_SHIFT = 16;
    localparam int ANG90 = 9000;
    localparam int ANG180 = 18000;
    localparam int GAIN_INV = 652032875;
    localparam int DIV_BITS = 16;
    localparam int NUM_W = 47;
    localparam int REM_W = 50;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [14:0] angle_t;

    typedef enum logic [0:0] {
        REG_CAMERA_PITCH      = 1'b0,
        REG_HEIGHT_DIFFERENCE = 1'b1
    } cfg_reg_t;

    // Status that leaves the divider together with the quotient.
    typedef struct packed {
        logic        ovf;
        logic [15:0] quot;
    } div_stat_t;

    // Arctangent of 2^-i in units of 1/65536 hundredth of a degree.
    function automatic val_t atan_unit(input int i);
        val_t r;
        case (i)
            0:  r = val_t'(294912000);
            1:  r = val_t'(174096719);
            2:  r = val_t'(91987925);
            3:  r = val_t'(46694507);
            4:  r = val_t'(23437865);
            5:  r = val_t'(11730358);
            6:  r = val_t'(5866610);
            7:  r = val_t'(2933484);
            8:  r = val_t'(1466764);
            9:  r = val_t'(733385);
            10: r = val_t'(366693);
            11: r = val_t'(183346);
            12: r = val_t'(91673);
            13: r = val_t'(45837);
            14: r = val_t'(22918);
            15: r = val_t'(11459);
            16: r = val_t'(5730);
            17: r = val_t'(2865);
            18: r = val_t'(1432);
            19: r = val_t'(716);
            20: r = val_t'(358);
            21: r = val_t'(179);
            22: r = val_t'(90);
            23: r = val_t'(45);
            24: r = val_t'(22);
            25: r = val_t'(11);
            26: r = val_t'(6);
            27: r = val_t'(3);
            28: r = val_t'(1);
            29: r = val_t'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Rounds an internal angle to hundredths (half away from zero) and clamps it.
    function automatic logic signed [17:0] round_clamp(input val_t v, input int lim);
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] sum;
        logic signed [17:0] r;
        logic signed [17:0] l;
        mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
        sum = mag + (VAL_W'(1) << (UNIT_SHIFT - 1));
        r = v[VAL_W-1] ? -$signed({1'b0, sum[UNIT_SHIFT+16:UNIT_SHIFT]})
                       : $signed({1'b0, sum[UNIT_SHIFT+16:UNIT_SHIFT]});
        l = 18'(lim);
        if (r > l)
        begin
            r = l;
        end
        else if (r < -l)
        begin
            r = -l;
        end
        return r;
    endfunction

endpackage

// ===== rtl/cpac_rotate.sv =====
// Pipelined rotation-mode CORDIC giving the cosine and sine of an angle in hundredths.
`timescale 1ns / 1ps

module cpac_rotate
    import cpac_pkg::*;
(
    input  logic   clk,
    input  logic   ce,
    input  angle_t angle,
    output val_t   cos_q,
    output val_t   sin_q
);

    val_t x_reg [0:CORDIC_STAGES];
    val_t y_reg [0:CORDIC_STAGES];
    val_t z_reg [0:CORDIC_STAGES];
    logic flip_reg [0:CORDIC_STAGES];
    val_t cos_reg;
    val_t sin_reg;

    logic signed [15:0] a_ext;
    logic signed [15:0] a_red;
    logic               a_flip;

    // Angles beyond a right angle are folded back and both results negated.
    always_comb
    begin
        a_ext  = {angle[14], angle};
        a_red  = a_ext;
        a_flip = 1'b0;
        if (a_ext > 16'(ANG90))
        begin
            a_red  = a_ext - 16'(ANG180);
            a_flip = 1'b1;
        end
        else if (a_ext < -16'(ANG90))
        begin
            a_red  = a_ext + 16'(ANG180);
            a_flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]    <= val_t'(GAIN_INV);
            y_reg[0]    <= '0;
            z_reg[0]    <= val_t'(a_red) <<< UNIT_SHIFT;
            flip_reg[0] <= a_flip;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (!z_reg[i][VAL_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_unit(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_unit(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cos_reg <= flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
            sin_reg <= flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ===== rtl/cpac_vector.sv =====
// Pipelined vectoring-mode CORDIC giving the angle and scaled length of a vector.
`timescale 1ns / 1ps

module cpac_vector
    import cpac_pkg::*;
(
    input  logic clk,
    input  logic ce,
    input  val_t x_in,
    input  val_t y_in,
    output val_t ang,
    output val_t mag
);

    val_t x_reg [0:CORDIC_STAGES];
    val_t y_reg [0:CORDIC_STAGES];
    val_t z_reg [0:CORDIC_STAGES];
    logic zero_reg [0:CORDIC_STAGES];

    val_t x0;
    val_t y0;
    val_t z0;

    // A vector in the left half plane is turned by half a circle first.
    always_comb
    begin
        x0 = x_in;
        y0 = y_in;
        z0 = '0;
        if (x_in[VAL_W-1])
        begin
            x0 = -x_in;
            y0 = -y_in;
            z0 = y_in[VAL_W-1] ? -(val_t'(ANG180) <<< UNIT_SHIFT)
                               : (val_t'(ANG180) <<< UNIT_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (!y_reg[i][VAL_W-1] && (y_reg[i] != '0))
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_unit(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_unit(i);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // The length of a zero vector stays zero through the stages by itself.
    assign ang = zero_reg[CORDIC_STAGES] ? val_t'(0) : z_reg[CORDIC_STAGES];
    assign mag = x_reg[CORDIC_STAGES];

endmodule

// ===== rtl/cpac_mulq.sv =====
// Two-stage Q30 multiplier with rounding half away from zero.
`timescale 1ns / 1ps

module cpac_mulq
    import cpac_pkg::*;
(
    input  logic clk,
    input  logic ce,
    input  val_t a,
    input  val_t b,
    output val_t p
);

    logic [2*VAL_W-3:0] prod_reg;
    logic               neg_reg;
    val_t               p_reg;

    logic [VAL_W-1:0]   a_mag;
    logic [VAL_W-1:0]   b_mag;
    logic [2*VAL_W-3:0] rnd;

    assign a_mag = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
    assign b_mag = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
    assign rnd   = prod_reg + ((2*VAL_W-2)'(1) << (QBITS - 1));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_reg <= a_mag[VAL_W-2:0] * b_mag[VAL_W-2:0];
            neg_reg  <= a[VAL_W-1] ^ b[VAL_W-1];
            p_reg    <= neg_reg ? -$signed(rnd[QBITS+VAL_W-1:QBITS])
                                : $signed(rnd[QBITS+VAL_W-1:QBITS]);
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/cpac_divide.sv =====
// Pipelined restoring divider for the rounded distance quotient, one bit per stage.
`timescale 1ns / 1ps

module cpac_divide
    import cpac_pkg::*;
(
    input  logic             clk,
    input  logic             ce,
    input  logic [NUM_W-1:0] num,
    input  val_t             den,
    output div_stat_t        stat
);

    logic [REM_W-1:0]    rem_reg  [0:DIV_BITS];
    logic [VAL_W-2:0]    d_reg    [0:DIV_BITS];
    logic [DIV_BITS-1:0] quot_reg [0:DIV_BITS];
    logic                ovf_reg  [0:DIV_BITS];

    logic [REM_W-1:0] n0;
    logic [REM_W-1:0] d_top;

    // Adding half the divisor makes the truncating quotient round to nearest.
    assign n0    = REM_W'(num) + REM_W'(den[VAL_W-2:1]);
    assign d_top = REM_W'(den[VAL_W-2:0]) << DIV_BITS;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0]  <= n0;
            d_reg[0]    <= den[VAL_W-2:0];
            quot_reg[0] <= '0;
            ovf_reg[0]  <= (n0 >= d_top);
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_stage
        logic [REM_W-1:0] dsh;
        assign dsh = REM_W'(d_reg[j]) << (DIV_BITS - 1 - j);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (rem_reg[j] >= dsh)
                begin
                    rem_reg[j+1] <= rem_reg[j] - dsh;
                    quot_reg[j+1] <= quot_reg[j] | (DIV_BITS'(1) << (DIV_BITS - 1 - j));
                end
                else
                begin
                    rem_reg[j+1] <= rem_reg[j];
                    quot_reg[j+1] <= quot_reg[j];
                end
                d_reg[j+1]   <= d_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign stat.ovf  = ovf_reg[DIV_BITS];
    assign stat.quot = quot_reg[DIV_BITS];

endmodule

// ===== rtl/camera_pitch_angle_correction.sv =====
// Throughput: one item per cycle when not stalled; every unit is a fully pipelined chain of
// CORDIC, multiplier and divider stages that advance together on one enable.
// A result waiting at the output stalls the chain only when a finished item is behind it.
// Reset (rst_n, asynchronous, active low) clears the valid bits and both registers to 0.
`timescale 1ns / 1ps

module camera_pitch_angle_correction
    import cpac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [14:0] horizontal_angle_in, [29:15] vertical_angle_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] horizontal_angle_out, [30:16] vertical_angle_out, [46:31] distance_mm
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,  // [0] distance_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int N = CORDIC_STAGES;
    localparam int DEPTH = 3 * N + 29;

    logic signed [14:0] pitch_reg;
    logic [13:0]        height_reg;
    logic               pv_reg [0:DEPTH-1];
    logic               out_vld_reg;
    logic [47:0]        out_data_reg;
    logic               out_user_reg;
    logic               ce;

    assign ce = !out_vld_reg || m_axis_tready || !pv_reg[DEPTH-1];
    assign s_axis_tready = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAMERA_PITCH:      pitch_reg  <= cfg_data;
                REG_HEIGHT_DIFFERENCE: height_reg <= cfg_data[13:0];
                default:               pitch_reg  <= pitch_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                pv_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            pv_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < DEPTH; k++)
            begin
                pv_reg[k] <= pv_reg[k-1];
            end
        end
    end

    // Sines and cosines of the three angles.
    val_t ch, sh, cv, sv, cp, sp;

    cpac_rotate u_rot_h (.clk(clk), .ce(ce), .angle(s_axis_tdata[14:0]), .cos_q(ch), .sin_q(sh));
    cpac_rotate u_rot_v (.clk(clk), .ce(ce), .angle(s_axis_tdata[29:15]), .cos_q(cv), .sin_q(sv));
    cpac_rotate u_rot_p (.clk(clk), .ce(ce), .angle(pitch_reg), .cos_q(cp), .sin_q(sp));

    // Direction vector.
    val_t vx, vy;
    val_t sv_dly [0:1];
    val_t cp_dly [0:1];
    val_t sp_dly [0:1];

    cpac_mulq u_mul_x (.clk(clk), .ce(ce), .a(cv), .b(sh), .p(vx));
    cpac_mulq u_mul_y (.clk(clk), .ce(ce), .a(cv), .b(ch), .p(vy));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sv_dly[0] <= sv;
            sv_dly[1] <= sv_dly[0];
            cp_dly[0] <= cp;
            cp_dly[1] <= cp_dly[0];
            sp_dly[0] <= sp;
            sp_dly[1] <= sp_dly[0];
        end
    end

    // Rotation about the x axis.
    val_t ycp, zsp, ysp, zcp;
    val_t vx_dly [0:1];
    val_t ry_reg, rz_reg, rx_reg;

    cpac_mulq u_mul_ycp (.clk(clk), .ce(ce), .a(vy), .b(cp_dly[1]), .p(ycp));
    cpac_mulq u_mul_zsp (.clk(clk), .ce(ce), .a(sv_dly[1]), .b(sp_dly[1]), .p(zsp));
    cpac_mulq u_mul_ysp (.clk(clk), .ce(ce), .a(vy), .b(sp_dly[1]), .p(ysp));
    cpac_mulq u_mul_zcp (.clk(clk), .ce(ce), .a(sv_dly[1]), .b(cp_dly[1]), .p(zcp));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vx_dly[0] <= vx;
            vx_dly[1] <= vx_dly[0];
            ry_reg    <= ycp - zsp;
            rz_reg    <= ysp + zcp;
            rx_reg    <= vx_dly[1];
        end
    end

    // Horizontal angle and ground-plane length.
    val_t hang, hmag, horiz;
    cpac_vector u_vec_h (.clk(clk), .ce(ce), .x_in(ry_reg), .y_in(rx_reg), .ang(hang), .mag(hmag));
    cpac_mulq u_mul_gain (.clk(clk), .ce(ce), .a(hmag), .b(val_t'(GAIN_INV)), .p(horiz));

    val_t hang_dly  [0:N+2];
    val_t rz_dly    [0:2*N+3];
    val_t horiz_dly [0:N];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hang_dly[0]  <= hang;
            rz_dly[0]    <= rz_reg;
            horiz_dly[0] <= horiz;
            for (int k = 1; k <= N + 2; k++)
            begin
                hang_dly[k] <= hang_dly[k-1];
            end
            for (int k = 1; k <= 2 * N + 3; k++)
            begin
                rz_dly[k] <= rz_dly[k-1];
            end
            for (int k = 1; k <= N; k++)
            begin
                horiz_dly[k] <= horiz_dly[k-1];
            end
        end
    end

    // Vertical angle.
    val_t vang, vmag_unused;
    cpac_vector u_vec_v (.clk(clk), .ce(ce), .x_in(horiz), .y_in(rz_dly[N+2]),
                         .ang(vang), .mag(vmag_unused));

    // Rounding, clamping and the distance numerator.
    // The angle and flag delays cover the numerator register and the divider stages.
    logic signed [17:0] hout_full, vout_full;
    logic [15:0]        hout_dly [0:DIV_BITS+1];
    logic [14:0]        vout_dly [0:DIV_BITS+1];
    logic               go_dly   [0:DIV_BITS+1];
    logic [NUM_W-1:0]   num_reg;
    val_t               den_reg;
    val_t               rz_f;
    val_t               horiz_f;
    logic [VAL_W-2:0]   horiz_pos;
    div_stat_t          dstat;

    assign hout_full = round_clamp(hang_dly[N+2], ANG180);
    assign vout_full = round_clamp(vang, ANG90);
    assign rz_f      = rz_dly[2*N+3];
    assign horiz_f   = horiz_dly[N];
    assign horiz_pos = horiz_f[VAL_W-1] ? '0 : horiz_f[VAL_W-2:0];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hout_dly[0] <= hout_full[15:0];
            vout_dly[0] <= vout_full[14:0];
            go_dly[0]   <= (vout_full > 18'sd0) && (rz_f > val_t'(0)) && (vmag_unused == vmag_unused);
            num_reg     <= NUM_W'(height_reg) * NUM_W'(horiz_pos);
            den_reg     <= rz_f;
            for (int k = 1; k <= DIV_BITS + 1; k++)
            begin
                hout_dly[k] <= hout_dly[k-1];
                vout_dly[k] <= vout_dly[k-1];
                go_dly[k]   <= go_dly[k-1];
            end
        end
    end

    cpac_divide u_div (.clk(clk), .ce(ce), .num(num_reg), .den(den_reg), .stat(dstat));

    // Output register.
    logic [15:0] dist_mm;
    assign dist_mm = !go_dly[DIV_BITS+1] ? 16'd0 : (dstat.ovf ? 16'hFFFF : dstat.quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ce && pv_reg[DEPTH-1])
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce && pv_reg[DEPTH-1])
        begin
            out_data_reg <= {1'b0, dist_mm, vout_dly[DIV_BITS+1], hout_dly[DIV_BITS+1]};
            out_user_reg <= go_dly[DIV_BITS+1] && !dstat.ovf;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // A valid distance needs a target above the corrected horizon.
    a_valid_above: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> $signed(m_axis_tdata[30:16]) > 0)
        else $error("valid distance with a non-positive vertical angle");

    // An invalid distance is either zero or saturated.
    a_invalid_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[46:31] == 16'd0) || (m_axis_tdata[46:31] == 16'hFFFF))
        else $error("invalid distance is neither zero nor saturated");

    // The horizontal result stays within half a circle.
    a_hout_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd18000) &&
                          ($signed(m_axis_tdata[15:0]) >= -16'sd18000))
        else $error("horizontal angle out of range");

    // A finished item never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && pv_reg[DEPTH-1] |-> !s_axis_tready)
        else $error("pipeline advanced into a held result");

endmodule

// ===== tb/camera_pitch_angle_correction_tb.sv =====
// Testbench for the camera pitch angle correction block: directed table, random items, self-check.
`timescale 1ns / 1ps

module camera_pitch_angle_correction_tb;
    import cpac_pkg::*;

    localparam int N_RANDOM = 1830;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 3 * CORDIC_STAGES + 60;

    typedef struct {
        logic signed [15:0] hout;
        logic signed [14:0] vout;
        logic [15:0]        dist_mm;
        logic               dvalid;
    } corr_t;

    typedef struct {
        int     h;
        int     v;
        bit     dist_typed;
        corr_t  typed;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_CAMERA_PITCH;
    logic [14:0] cfg_data = '0;

    longint pitch_reg = 0;
    longint height_reg = 0;
    corr_t  pending_q[$];
    int     n_errors = 0;
    int     n_results = 0;
    int     idle_cycles = 0;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_cnt = 0;
    int     sink_stall = 0;

    longint atan_tab[32] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610,
        2933484, 1466764, 733385, 366693, 183346, 91673, 45837, 22918, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0
    };

    camera_pitch_angle_correction u_top (.*);

    always #5 clk = ~clk;

    function automatic longint unsigned magnitude(input longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    // Q30 product, rounded half away from zero.
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned p;
        longint r;
        p = magnitude(a) * magnitude(b);
        r = longint'((p + (64'd1 << (QBITS - 1))) >> QBITS);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    task automatic sin_cos(input longint hund, output longint c, output longint s);
        bit flip;
        longint x, y, z, t;
        flip = 1'b0;
        x = GAIN_INV;
        y = 0;
        // Angles past ninety degrees fold back onto the other half of the circle.
        if (hund > ANG90)
        begin
            hund -= ANG180;
            flip = 1'b1;
        end
        else if (hund < -ANG90)
        begin
            hund += ANG180;
            flip = 1'b1;
        end
        z = hund * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z -= atan_tab[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic to_polar(input longint xi, input longint yi, output longint ang,
                            output longint len);
        longint x, y, z, t;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
        begin
            ang = 0;
            len = 0;
        end
        else
        begin
            if (x < 0)
            begin
                z = ((y >= 0) ? ANG180 : -ANG180) * 64'sd65536;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
            begin
                if (y > 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    x = t;
                    z += atan_tab[i];
                end
                else
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    x = t;
                    z -= atan_tab[i];
                end
            end
            ang = z;
            len = q30_mul(x, GAIN_INV);
        end
    endtask

    function automatic longint hundredths_clamped(input longint v, input longint lim);
        longint unsigned m;
        longint r;
        m = (magnitude(v) + (64'd1 << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
        r = (v < 0) ? -longint'(m) : longint'(m);
        return (r > lim) ? lim : ((r < -lim) ? -lim : r);
    endfunction

    task automatic correct_angles(input int h, input int v, output corr_t res);
        longint ch, sh, cv, sv, cp, sp, x, y, ry, rz, hang, horiz, vang, unused_len;
        longint hout, vout;
        longint unsigned num, q;
        sin_cos(h, ch, sh);
        sin_cos(v, cv, sv);
        sin_cos(pitch_reg, cp, sp);
        x = q30_mul(cv, sh);
        y = q30_mul(cv, ch);
        ry = q30_mul(y, cp) - q30_mul(sv, sp);
        rz = q30_mul(y, sp) + q30_mul(sv, cp);
        to_polar(ry, x, hang, horiz);
        to_polar(horiz, rz, vang, unused_len);
        hout = hundredths_clamped(hang, ANG180);
        vout = hundredths_clamped(vang, ANG90);
        res.hout = hout[15:0];
        res.vout = vout[14:0];
        res.dist_mm = '0;
        res.dvalid = 1'b0;
        if (vout > 0 && rz > 0)
        begin
            num = longint'(height_reg) * ((horiz < 0) ? 0 : horiz);
            q = (num + longint'(rz) / 2) / longint'(rz);
            if (q > 65535)
            begin
                res.dist_mm = 16'hFFFF;
            end
            else
            begin
                res.dist_mm = q[15:0];
                res.dvalid = 1'b1;
            end
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[14:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_CAMERA_PITCH)
        begin
            pitch_reg = longint'($signed(value[14:0]));
        end
        else
        begin
            height_reg = value & 16'h3FFF;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits for every pending result and for the pipeline to empty behind it.
    task automatic drain();
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pair(input int h, input int v, input bit typed, input corr_t tv);
        corr_t res;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, v[14:0], h[14:0]};
        do @(posedge clk); while (!s_axis_tready);
        correct_angles(int'($signed(h[14:0])), int'($signed(v[14:0])), res);
        if (typed)
        begin
            res.dist_mm = tv.dist_mm;
            res.dvalid = tv.dvalid;
        end
        pending_q = {pending_q, res};
    endtask

    function automatic int rand_angle();
        int r;
        if ($urandom_range(0, 7) == 0)
        begin
            r = $signed(15'($urandom_range(0, 32767)));
        end
        else
        begin
            r = $urandom_range(0, 18000) - 9000;
        end
        return r;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        corr_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.hout = m_axis_tdata[15:0];
            got.vout = m_axis_tdata[30:16];
            got.dist_mm = m_axis_tdata[46:31];
            got.dvalid = m_axis_tuser;
            n_results++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result h=%0d v=%0d d=%0d ok=%0d", $time,
                         got.hout, got.vout, got.dist_mm, got.dvalid);
                n_errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.hout !== want.hout)
                begin
                    $display("%0t: horizontal_angle_out expected %0d actual %0d", $time,
                             want.hout, got.hout);
                    n_errors++;
                end
                if (got.vout !== want.vout)
                begin
                    $display("%0t: vertical_angle_out expected %0d actual %0d", $time,
                             want.vout, got.vout);
                    n_errors++;
                end
                if (got.dist_mm !== want.dist_mm)
                begin
                    $display("%0t: distance_mm expected %0d actual %0d", $time,
                             want.dist_mm, got.dist_mm);
                    n_errors++;
                end
                if (got.dvalid !== want.dvalid)
                begin
                    $display("%0t: distance_valid expected %0d actual %0d", $time,
                             want.dvalid, got.dvalid);
                    n_errors++;
                end
            end
        end
    end

    // Receiver readiness: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= (hold_cnt == 1);
        end
        else if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            sink_stall <= $urandom_range(1, 12) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // A run with no transaction for too long counts as a hang.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        corr_t none;
        corr_t not_pos;
        int pitches[5];
        int heights[5];
        int n_done;
        none = '{default: '0};
        not_pos = '{default: '0};
        // At reset pitch a target below the horizon has no valid distance.
        rows = '{
            '{0, 0, 0, none}, '{9000, 0, 0, none}, '{-9000, 0, 0, none},
            '{0, 9000, 0, none}, '{0, -9000, 1, not_pos}, '{0, -4500, 1, not_pos},
            '{4500, -3000, 1, not_pos}, '{9000, 9000, 0, none},
            '{-9000, -9000, 1, not_pos}, '{16383, -16384, 0, none},
            '{-16384, 16383, 0, none}, '{16383, 16383, 0, none},
            '{-16384, -16384, 0, none}, '{12000, 5000, 0, none},
            '{-12000, -5000, 0, none}, '{1, 1, 0, none}, '{-1, -1, 0, none},
            '{18000 - 16384 - 1, 2500, 0, none}, '{0, 1, 0, none}, '{0, -1, 0, none}
        };
        pitches = '{-9000, 9000, -16384, 16383, 1500};
        heights = '{16383, 1, 0, 12000, 700};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_pair(rows[i].h, rows[i].v, rows[i].dist_typed, rows[i].typed);
        end

        n_done = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            drain();
            if (ph < 5)
            begin
                write_reg(REG_CAMERA_PITCH, pitches[ph]);
                write_reg(REG_HEIGHT_DIFFERENCE, heights[ph]);
            end
            else
            begin
                write_reg(REG_CAMERA_PITCH, $urandom_range(0, 18000) - 9000);
                write_reg(REG_HEIGHT_DIFFERENCE, $urandom_range(0, 16383));
            end
            for (int k = 0; k < N_RANDOM / 6; k++)
            begin
                if (ph == 1 && k == 50)
                begin
                    hold_req = 1'b1;
                end
                if (ph == 5 && k > N_RANDOM / 12)
                begin
                    quiet = 1'b1;
                end
                send_pair(rand_angle(), rand_angle(), 1'b0, none);
                n_done++;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        drain();

        $display("Ran %0d directed and %0d random angle pairs over 7 register settings,",
                 rows.size(), n_done);
        $display("including extreme pitches and heights; %0d results checked.", n_results);
        if (n_errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
